@@ design/nat_flow_rewriter_assert.svh @@
// Assertion macros for the NAT flow rewriter.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef NAT_FLOW_REWRITER_ASSERT_SVH
`define NAT_FLOW_REWRITER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define NFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define NFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/nfr_pkg.sv @@
// Types and constants shared by the NAT flow rewriter.
// No dependencies.
`default_nettype none

package nfr_pkg;

  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] MIN_TRANSPORT  = 16'd8;
  localparam logic [31:0] NAT_ADDR_RESET = 32'hdeadbeef;

  localparam int unsigned CFG_AW = 5;
  localparam logic [2:0] REG_NAT_SRC_ADDR = 3'd0;
  localparam logic [2:0] REG_IN0_PASS     = 3'd1;
  localparam logic [2:0] REG_IN0_OUT_PORT = 3'd2;
  localparam logic [2:0] REG_IN0_BASE     = 3'd3;
  localparam logic [2:0] REG_IN1_PASS     = 3'd4;
  localparam logic [2:0] REG_IN1_OUT_PORT = 3'd5;
  localparam logic [2:0] REG_IN1_BASE     = 3'd6;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_DONE
  } nfr_state_e;

  typedef struct packed {
    logic        in_port;
    logic [7:0]  protocol;
    logic        first_fragment;
    logic [15:0] transport_len;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } pkt_in_t;

  typedef struct packed {
    logic        forward;
    logic [2:0]  out_port;
    logic [31:0] new_src_addr;
    logic [31:0] new_dst_addr;
    logic [15:0] new_src_port;
    logic [15:0] new_dst_port;
    logic        flow_hit;
    logic        table_full;
  } pkt_out_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] addrs;
    logic [32:0] ports_proto;
    logic [47:0] new_source;
  } flow_entry_t;

endpackage

`default_nettype wire

@@ design/nfr_stream_if.sv @@
// Valid/ready stream channel carrying one payload struct.
// Payload type comes from nfr_pkg at instantiation.
`default_nettype none

interface nfr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/nfr_flow_ram.sv @@
// Single-port-write, single-port-read flow table memory, registered read.
// Depends on nfr_pkg for the entry type.
`default_nettype none

module nfr_flow_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire nfr_pkg::flow_entry_t wdata_i,
  input  wire logic [AW-1:0]        raddr_i,
  output nfr_pkg::flow_entry_t      rdata_o
);
  import nfr_pkg::*;

  flow_entry_t mem_q [DEPTH];
  flow_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/nat_flow_rewriter.sv @@
// Source NAT rewriter over a linear-probed exact-match flow table.
// Depends on nfr_pkg, nfr_stream_if, nfr_flow_ram, nat_flow_rewriter_assert.svh.
//
//   channel   direction  handshake              payload
//   in_i      sink       valid/ready            nfr_pkg::pkt_in_t
//   out_o     source     valid/ready            nfr_pkg::pkt_out_t
//   apb       slave      psel/penable/pready    32-bit registers
//
// After reset a clearing pass walks all FLOW_ENTRIES table entries before any
// request is taken. An unrewritable request skips the table; a rewritable one
// probes it, one memory read per cycle, up to FLOW_ENTRIES probes when the
// table is full. A new request is taken while the previous result waits in
// the output register.
`default_nettype none

`include "nat_flow_rewriter_assert.svh"

module nat_flow_rewriter #(
  parameter int unsigned FLOW_ENTRIES = 1024,
  parameter int unsigned NUM_INPUTS   = 2
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  nfr_stream_if.sink                  in_i,
  nfr_stream_if.source                out_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [nfr_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import nfr_pkg::*;

  localparam int unsigned IDX_W  = $clog2(FLOW_ENTRIES);
  localparam int unsigned KEY_W  = 97;
  localparam int unsigned CHUNKS = (KEY_W + IDX_W - 1) / IDX_W;
  localparam int unsigned PAD_W  = CHUNKS * IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);
  localparam logic [IDX_W:0]   DEPTH_W  = (IDX_W+1)'(FLOW_ENTRIES);

  nfr_state_e state_q, state_d;

  // configuration
  logic [31:0] nat_addr_q;
  logic [1:0]  pass_q;
  logic [2:0]  oport_q [2];
  logic [15:0] base_q  [2];
  logic [15:0] cnt_q   [NUM_INPUTS];

  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[CFG_AW-1:2];

  always_comb begin
    unique case (cfg_idx)
      REG_NAT_SRC_ADDR: prdata = nat_addr_q;
      REG_IN0_PASS:     prdata = {31'd0, pass_q[0]};
      REG_IN0_OUT_PORT: prdata = {29'd0, oport_q[0]};
      REG_IN0_BASE:     prdata = {16'd0, base_q[0]};
      REG_IN1_PASS:     prdata = {31'd0, pass_q[1]};
      REG_IN1_OUT_PORT: prdata = {29'd0, oport_q[1]};
      REG_IN1_BASE:     prdata = {16'd0, base_q[1]};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nat_addr_q <= NAT_ADDR_RESET;
      pass_q     <= 2'b00;
      oport_q[0] <= 3'd0;
      oport_q[1] <= 3'd1;
      base_q[0]  <= 16'd0;
      base_q[1]  <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_NAT_SRC_ADDR: nat_addr_q <= pwdata;
        REG_IN0_PASS:     pass_q[0]  <= pwdata[0];
        REG_IN0_OUT_PORT: oport_q[0] <= pwdata[2:0];
        REG_IN0_BASE:     base_q[0]  <= pwdata[15:0];
        REG_IN1_PASS:     pass_q[1]  <= pwdata[0];
        REG_IN1_OUT_PORT: oport_q[1] <= pwdata[2:0];
        REG_IN1_BASE:     base_q[1]  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // request classification
  pkt_in_t     req, item_q;
  logic        in_fire, port_ok, rewritable;
  logic [2:0]  item_oport;
  logic [IDX_W-1:0] hash, idx_q, probes_q, clr_q, next_idx;
  logic [PAD_W-1:0] key_pad;
  logic [IDX_W-1:0] fold;
  logic [IDX_W:0]   fold_w;

  assign req     = in_i.payload;
  assign in_fire = in_i.valid & in_i.ready;
  assign port_ok = 32'(req.in_port) < NUM_INPUTS;
  assign rewritable = ((req.protocol == PROTO_TCP) || (req.protocol == PROTO_UDP)) &&
                      req.first_fragment && (req.transport_len >= MIN_TRANSPORT);

  // fold the 97-bit key into a table index
  always_comb begin
    key_pad = PAD_W'({req.src_addr, req.dst_addr, req.src_port, req.dst_port,
                      req.protocol == PROTO_TCP});
    fold = '0;
    for (int k = 0; k < CHUNKS; k++) begin
      fold = fold ^ key_pad[k*IDX_W +: IDX_W];
    end
    fold_w = {1'b0, fold};
    hash = (fold_w >= DEPTH_W) ? IDX_W'(fold_w - DEPTH_W) : fold;
  end

  assign next_idx   = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  assign item_oport = oport_q[item_q.in_port];

  // table probe
  flow_entry_t rd, wdata;
  logic        we;
  logic [IDX_W-1:0] raddr, waddr;
  logic        key_match, hit, empty, exhausted;
  logic [15:0] cnt_cur, cnt_inc;

  always_comb begin
    cnt_cur = '0;
    for (int i = 0; i < NUM_INPUTS; i++) begin
      if (32'(item_q.in_port) == i) cnt_cur = cnt_q[i];
    end
  end
  assign cnt_inc = cnt_cur + 16'd1;

  assign key_match = (rd.addrs == {item_q.src_addr, item_q.dst_addr}) &&
                     (rd.ports_proto == {item_q.src_port, item_q.dst_port,
                                         item_q.protocol == PROTO_TCP});
  assign hit       = rd.valid & key_match;
  assign empty     = ~rd.valid;
  assign exhausted = (probes_q == LAST_IDX);

  nfr_flow_ram #(
    .DEPTH (FLOW_ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == LAST_IDX) state_d = S_IDLE;
      S_IDLE:  if (in_fire) state_d = (port_ok && rewritable) ? S_PROBE : S_DONE;
      S_PROBE: if (hit || empty || exhausted) state_d = S_DONE;
      S_DONE:  if (!out_o.valid || out_o.ready) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // outputs of the controller
  pkt_out_t res_d;
  logic     cnt_adv;

  always_comb begin
    in_i.ready = 1'b0;
    we         = 1'b0;
    waddr      = idx_q;
    wdata      = '0;
    raddr      = next_idx;
    cnt_adv    = 1'b0;
    res_d      = '0;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
      end
      S_IDLE: begin
        in_i.ready = 1'b1;
        raddr      = hash;
      end
      S_PROBE: begin
        res_d.forward      = 1'b1;
        res_d.out_port     = item_oport;
        res_d.new_dst_addr = item_q.dst_addr;
        res_d.new_dst_port = item_q.dst_port;
        if (hit) begin
          res_d.new_src_addr = rd.new_source[47:16];
          res_d.new_src_port = rd.new_source[15:0];
          res_d.flow_hit     = 1'b1;
        end else if (empty || exhausted) begin
          cnt_adv            = 1'b1;
          res_d.new_src_addr = nat_addr_q;
          res_d.new_src_port = cnt_inc;
          res_d.table_full   = ~empty;
          // insert into the free slot, if the probe found one
          we    = empty;
          wdata = '{valid: 1'b1,
                    addrs: {item_q.src_addr, item_q.dst_addr},
                    ports_proto: {item_q.src_port, item_q.dst_port,
                                  item_q.protocol == PROTO_TCP},
                    new_source: {nat_addr_q, cnt_inc}};
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  pkt_out_t res_q, out_q;
  logic     out_vld_q;

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_DONE && (!out_vld_q || out_o.ready)) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // port counters, loaded by base port writes
  for (genvar g = 0; g < NUM_INPUTS; g++) begin : g_cnt
    localparam logic [2:0] BASE_REG = (g == 0) ? REG_IN0_BASE : REG_IN1_BASE;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[g] <= 16'd0;
      end else if (cfg_we && cfg_idx == BASE_REG) begin
        cnt_q[g] <= pwdata[15:0];
      end else if (cnt_adv && 32'(item_q.in_port) == g) begin
        cnt_q[g] <= cnt_inc;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q   <= req;
      idx_q    <= hash;
      probes_q <= '0;
      res_q    <= '0;
      if (port_ok && !rewritable && pass_q[req.in_port]) begin
        res_q <= '{forward: 1'b1, out_port: oport_q[req.in_port],
                   new_src_addr: req.src_addr, new_dst_addr: req.dst_addr,
                   new_src_port: req.src_port, new_dst_port: req.dst_port,
                   flow_hit: 1'b0, table_full: 1'b0};
      end
    end else if (state_q == S_PROBE) begin
      idx_q    <= next_idx;
      probes_q <= probes_q + 1'b1;
      res_q    <= res_d;
    end
    if (state_q == S_DONE && (!out_vld_q || out_o.ready)) begin
      out_q <= res_q;
    end
  end

  `NFR_ASSERT_NOW(a_no_req_in_clear, state_q == S_CLEAR, !in_i.ready, "request taken during clear")
  `NFR_ASSERT_NOW(a_insert_free, we && state_q == S_PROBE, !rd.valid, "insert over a live entry")
  `NFR_ASSERT_NEXT(a_hit_result, state_q == S_PROBE && hit, res_q.forward && !res_q.table_full, "hit result malformed")
  `NFR_ASSERT_NEXT(a_out_hold, out_vld_q && !out_o.ready, out_vld_q && $stable(out_q), "result lost")

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking bench for the NAT flow rewriter: drives packet headers and
// APB register writes, and predicts every result from a flow table of its own.
// Depends on nfr_pkg, nfr_stream_if and the nat_flow_rewriter RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nfr_pkg::*;

  localparam int unsigned TABLE_SIZE = 1024;
  localparam longint unsigned CYCLE_LIMIT = 8000000;
  localparam int unsigned PHASE_ITEMS = 520;
  localparam int unsigned FILL_ITEMS = 920;

  logic clk_i = 1'b1;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  nfr_stream_if #(.T(pkt_in_t)) req_if ();
  nfr_stream_if #(.T(pkt_out_t)) res_if ();

  nat_flow_rewriter uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_if.sink), .out_o(res_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    req_if.valid = 1'b0;
    req_if.payload = '0;
    res_if.ready = 1'b0;
  end

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Register shadow and mapping state
  logic [31:0] nat_addr_q = NAT_ADDR_RESET;
  logic pass_q [2] = '{1'b0, 1'b0};
  logic [2:0] oport_q [2] = '{3'd0, 3'd1};
  logic [15:0] counter_q [2] = '{16'd0, 16'd0};
  logic [47:0] mapping_q [logic [96:0]];
  int unsigned mappings_used = 0;

  pkt_in_t pkt_q [$];
  pkt_out_t expected_q [$];
  pkt_in_t flows_seen [$];
  int unsigned n_sent = 0, n_results = 0, n_errors = 0;
  int unsigned n_hits = 0, n_full = 0, n_drops = 0;
  longint unsigned n_cycles = 0;

  function automatic void queue_req(pkt_in_t p);
    pkt_q.insert(pkt_q.size(), p);
  endfunction

  function automatic pkt_out_t nat_predict(pkt_in_t p);
    pkt_out_t r;
    logic [96:0] key;
    r = '0;
    if (!((p.protocol == PROTO_TCP || p.protocol == PROTO_UDP) && p.first_fragment
          && p.transport_len >= MIN_TRANSPORT)) begin
      if (pass_q[p.in_port]) begin
        r = '{1'b1, oport_q[p.in_port], p.src_addr, p.dst_addr, p.src_port,
              p.dst_port, 1'b0, 1'b0};
      end
      return r;
    end
    key = {p.src_addr, p.dst_addr, p.src_port, p.dst_port, p.protocol == PROTO_TCP};
    r.forward = 1'b1;
    r.out_port = oport_q[p.in_port];
    r.new_dst_addr = p.dst_addr;
    r.new_dst_port = p.dst_port;
    if (mapping_q.exists(key)) begin
      {r.new_src_addr, r.new_src_port} = mapping_q[key];
      r.flow_hit = 1'b1;
      return r;
    end
    counter_q[p.in_port] = counter_q[p.in_port] + 16'd1;
    r.new_src_addr = nat_addr_q;
    r.new_src_port = counter_q[p.in_port];
    if (mappings_used >= TABLE_SIZE) begin
      r.table_full = 1'b1;
    end else begin
      mapping_q[key] = {nat_addr_q, counter_q[p.in_port]};
      mappings_used++;
    end
    return r;
  endfunction

  // Request driver
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    n_cycles++;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        expected_q.insert(expected_q.size(), nat_predict(req_if.payload));
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pkt_q.size() > 0) begin
          req_if.payload <= pkt_q.pop_front();
          req_if.valid <= 1'b1;
          n_sent++;
          gap_left = ((n_sent % 200) < 40) ? 0 : $urandom_range(0, 5);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        pkt_out_t got, want;
        got = res_if.payload;
        n_results++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: %p", got);
          n_errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.forward !== want.forward) begin
            $error("forward exp %0h got %0h", want.forward, got.forward); n_errors++;
          end
          if (got.out_port !== want.out_port) begin
            $error("out_port exp %0h got %0h", want.out_port, got.out_port); n_errors++;
          end
          if (got.new_src_addr !== want.new_src_addr) begin
            $error("new_src_addr exp %0h got %0h", want.new_src_addr, got.new_src_addr);
            n_errors++;
          end
          if (got.new_dst_addr !== want.new_dst_addr) begin
            $error("new_dst_addr exp %0h got %0h", want.new_dst_addr, got.new_dst_addr);
            n_errors++;
          end
          if (got.new_src_port !== want.new_src_port) begin
            $error("new_src_port exp %0h got %0h", want.new_src_port, got.new_src_port);
            n_errors++;
          end
          if (got.new_dst_port !== want.new_dst_port) begin
            $error("new_dst_port exp %0h got %0h", want.new_dst_port, got.new_dst_port);
            n_errors++;
          end
          if (got.flow_hit !== want.flow_hit) begin
            $error("flow_hit exp %0h got %0h", want.flow_hit, got.flow_hit); n_errors++;
          end
          if (got.table_full !== want.table_full) begin
            $error("table_full exp %0h got %0h", want.table_full, got.table_full);
            n_errors++;
          end
          n_hits += want.flow_hit;
          n_full += want.table_full;
          n_drops += !want.forward;
        end
        stall_left = ((n_results % 170) < 30) ? 0 : $urandom_range(0, 5);
        // hold off long enough to back the block up into its input
        if (n_results == 150) stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (n_cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_NAT_SRC_ADDR: nat_addr_q = val;
      REG_IN0_PASS:     pass_q[0] = val[0];
      REG_IN0_OUT_PORT: oport_q[0] = val[2:0];
      REG_IN0_BASE:     counter_q[0] = val[15:0];
      REG_IN1_PASS:     pass_q[1] = val[0];
      REG_IN1_OUT_PORT: oport_q[1] = val[2:0];
      REG_IN1_BASE:     counter_q[1] = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pkt_q.size() > 0 || req_if.valid || expected_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic pkt_in_t mk_pkt(logic port, logic [7:0] proto, logic first,
                                     logic [15:0] tlen, logic [31:0] sa, logic [31:0] da,
                                     logic [15:0] sp, logic [15:0] dp);
    pkt_in_t p;
    p = '{port, proto, first, tlen, sa, da, sp, dp};
    if ((proto == PROTO_TCP || proto == PROTO_UDP) && first && tlen >= MIN_TRANSPORT)
      flows_seen.insert(flows_seen.size(), p);
    return p;
  endfunction

  // a new rewritable flow with a random tuple
  function automatic pkt_in_t fresh_pkt();
    logic [7:0] proto;
    proto = ($urandom_range(0, 1) != 0) ? PROTO_TCP : PROTO_UDP;
    return mk_pkt(1'($urandom_range(0, 1)), proto, 1'b1, 16'($urandom_range(8, 65535)),
                  $urandom(), $urandom(), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
  endfunction

  function automatic pkt_in_t random_pkt();
    pkt_in_t p;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40 && flows_seen.size() > 0) begin
      // replay a known flow, possibly from the other input
      p = flows_seen[$urandom_range(0, flows_seen.size() - 1)];
      p.in_port = 1'($urandom_range(0, 1));
      p.transport_len = 16'($urandom_range(8, 65535));
      return p;
    end
    if (pick < 80) return fresh_pkt();
    p.protocol = ($urandom_range(0, 3) == 0) ? PROTO_TCP : 8'($urandom_range(0, 255));
    p.first_fragment = 1'($urandom_range(0, 1));
    p.transport_len = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 9))
                                                  : 16'($urandom_range(0, 65535));
    return mk_pkt(1'($urandom_range(0, 1)), p.protocol, p.first_fragment, p.transport_len,
                  $urandom(), $urandom(), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: drops on both inputs, one mapping with the reset address
    queue_req(mk_pkt(1'b0, 8'd1, 1'b1, 16'd64, 32'h01020304, 32'h05060708, 16'd1, 16'd2));
    queue_req(mk_pkt(1'b1, PROTO_TCP, 1'b0, 16'd64, 32'h0, 32'h0, 16'd0, 16'd0));
    queue_req(mk_pkt(1'b1, PROTO_UDP, 1'b1, 16'd8, 32'hc0a80001, 32'h08080808,
                     16'd5353, 16'd53));
    wait_idle();

    reg_write(REG_NAT_SRC_ADDR, 32'hffffffff);
    reg_write(REG_IN0_PASS, 32'd1);
    reg_write(REG_IN0_OUT_PORT, 32'd7);
    reg_write(REG_IN0_BASE, 32'h0000fffe);
    reg_write(REG_IN1_PASS, 32'd0);
    reg_write(REG_IN1_OUT_PORT, 32'd0);
    reg_write(REG_IN1_BASE, 32'h0000ffff);
    queue_req(mk_pkt(1'b0, 8'd0, 1'b1, 16'd100, 32'h11111111, 32'h22222222, 16'd3, 16'd4));
    queue_req(mk_pkt(1'b0, 8'd255, 1'b1, 16'hffff, 32'hffffffff, 32'hffffffff,
                     16'hffff, 16'hffff));
    queue_req(mk_pkt(1'b0, PROTO_TCP, 1'b0, 16'd40, 32'h0a000001, 32'h0a000002,
                     16'd80, 16'd81));
    queue_req(mk_pkt(1'b0, PROTO_UDP, 1'b1, 16'd7, 32'h0a000003, 32'h0a000004,
                     16'd90, 16'd91));
    queue_req(mk_pkt(1'b1, PROTO_UDP, 1'b1, 16'd0, 32'h0a000005, 32'h0a000006,
                     16'd92, 16'd93));
    // counter wrap on input 0, then on input 1
    queue_req(mk_pkt(1'b0, PROTO_TCP, 1'b1, 16'd8, 32'h0, 32'h0, 16'h0, 16'h0));
    queue_req(mk_pkt(1'b0, PROTO_TCP, 1'b1, 16'hffff, 32'hffffffff, 32'hffffffff,
                     16'hffff, 16'hffff));
    queue_req(mk_pkt(1'b0, PROTO_UDP, 1'b1, 16'd20, 32'h0, 32'h0, 16'h0, 16'h0));
    queue_req(mk_pkt(1'b1, PROTO_UDP, 1'b1, 16'd20, 32'hc0a80101, 32'h01010101,
                     16'd1000, 16'd443));
    // same tuples again from either input: two hits, then the UDP tuple as TCP, a new flow
    queue_req(mk_pkt(1'b1, PROTO_TCP, 1'b1, 16'd9, 32'h0, 32'h0, 16'h0, 16'h0));
    queue_req(mk_pkt(1'b0, PROTO_UDP, 1'b1, 16'd30, 32'hc0a80101, 32'h01010101,
                     16'd1000, 16'd443));
    queue_req(mk_pkt(1'b1, PROTO_TCP, 1'b1, 16'd30, 32'hc0a80101, 32'h01010101,
                     16'd1000, 16'd443));
    wait_idle();

    reg_write(REG_NAT_SRC_ADDR, $urandom());
    reg_write(REG_IN0_OUT_PORT, $urandom_range(0, 7));
    reg_write(REG_IN1_PASS, 32'd1);
    reg_write(REG_IN1_BASE, $urandom_range(0, 65535));
    repeat (PHASE_ITEMS) queue_req(random_pkt());
    wait_idle();

    // new flows only, enough to fill the table and spill past it
    reg_write(REG_NAT_SRC_ADDR, 32'h0);
    reg_write(REG_IN0_PASS, 32'd0);
    reg_write(REG_IN0_BASE, 32'h0);
    reg_write(REG_IN1_OUT_PORT, 32'd7);
    repeat (FILL_ITEMS) queue_req(fresh_pkt());
    wait_idle();

    // table is full by now; keep mixing hits and unstored misses
    reg_write(REG_IN0_PASS, 32'd1);
    reg_write(REG_IN1_PASS, 32'd0);
    reg_write(REG_IN0_BASE, 32'h0000fff0);
    repeat (PHASE_ITEMS) queue_req(random_pkt());
    wait_idle();
    repeat (50) @(posedge clk_i);

    $display("Covered %0d requests, %0d results: %0d hits, %0d table-full misses, %0d drops.",
             n_sent, n_results, n_hits, n_full, n_drops);
    $display("Flow table held %0d mappings at the end.", mappings_used);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+design
design/nfr_pkg.sv
design/nfr_stream_if.sv
design/nfr_flow_ram.sv
design/nat_flow_rewriter.sv
test/tb.sv
